// File: rtl/core/ttlkc_pkg.sv
// Package for the expiring-entry cache table: widths, codes, command/status structs.
`default_nettype none
package ttlkc_pkg;
   localparam int ENTRIES_DEFAULT = 64;
   localparam int KEY_W = 64;
   localparam int FAM_W = 8;
   localparam int VAL_W = 64;
   localparam int TIME_W = 64;
   localparam int TTL_W = 31;
   localparam int CNT_W = 32;
   localparam int PCT_W = 7;
   localparam int PURGE_W = 7;
   localparam int MS_PER_S = 1000;
   localparam int PCT_SCALE = 100;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_LOOKUP = 2'd1,
      KIND_PURGE  = 2'd2,
      KIND_QUERY  = 2'd3
   } kind_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request
      logic scan_start; // reset scan index
      logic scan_step;  // examine one entry
      logic do_update;  // overwrite matched entry
      logic do_evict;   // move last entry into victim slot
      logic do_append;  // write new entry at count
      logic purge_fin;  // commit kept count
      logic hit;        // bump hit counter
      logic miss;       // bump miss counter
      logic div_start;
      logic rsp_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      kind_type kind;
      logic     scan_done;  // scan index reached count
      logic     match;      // current read entry matches
      logic     live;       // current read entry not expired
      logic     full;
      logic     div_done;
   } sts_type;
endpackage
`default_nettype wire

// File: rtl/core/ttlkc_div.sv
// Restoring divider for the hit percentage: one quotient bit per cycle.
`default_nettype none
module ttlkc_div (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [ttlkc_pkg::CNT_W-1:0] hits,
   input  wire logic [ttlkc_pkg::CNT_W-1:0] misses,
   output logic                          done,
   output logic [ttlkc_pkg::PCT_W-1:0]   pct
);
   import ttlkc_pkg::*;
   localparam int NUM_W = CNT_W + PCT_W;
   localparam int DEN_W = CNT_W + 1;
   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    trial;

   // one shift-subtract step
   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[DEN_W-1:0], num_ff[NUM_W-1]};
      if (start) begin
         num_in = NUM_W'(hits) * NUM_W'(PCT_SCALE);
         den_in = DEN_W'(hits) + DEN_W'(misses);
         rem_in = '0;
         step_in = STEP_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (den_ff == '0) begin
            num_in = '0;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = trial - {1'b0, den_ff};
               num_in = {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial;
               num_in = {num_ff[NUM_W-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign pct = num_ff[PCT_W-1:0];
endmodule
`default_nettype wire

// File: rtl/core/ttlkc_datapath.sv
// Datapath: entry memory, scan index, victim search, purge compaction, counters, result regs.
`default_nettype none
module ttlkc_datapath #(
   parameter int ENTRIES = ttlkc_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ttlkc_pkg::cmd_type           cmd,
   output ttlkc_pkg::sts_type                sts,
   input  wire logic [1:0]                   req_kind,
   input  wire logic [ttlkc_pkg::KEY_W-1:0]  req_host_key,
   input  wire logic [ttlkc_pkg::FAM_W-1:0]  req_family,
   input  wire logic [ttlkc_pkg::VAL_W-1:0]  req_addr_high,
   input  wire logic [ttlkc_pkg::VAL_W-1:0]  req_addr_low,
   input  wire logic [ttlkc_pkg::TTL_W-1:0]  req_ttl_seconds,
   input  wire logic [ttlkc_pkg::TIME_W-1:0] req_now_ms,
   output logic                              rsp_status,
   output logic [ttlkc_pkg::VAL_W-1:0]       rsp_found_addr_high,
   output logic [ttlkc_pkg::VAL_W-1:0]       rsp_found_addr_low,
   output logic [ttlkc_pkg::PURGE_W-1:0]     rsp_purged_count,
   output logic [ttlkc_pkg::PCT_W-1:0]       rsp_hit_percent
);
   import ttlkc_pkg::*;
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CT_W = $clog2(ENTRIES + 1);
   localparam int REC_W = KEY_W + FAM_W + 2 * VAL_W + TIME_W;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [FAM_W-1:0]  fam;
      logic [VAL_W-1:0]  vhi;
      logic [VAL_W-1:0]  vlo;
      logic [TIME_W-1:0] exp;
   } rec_type;

   // entry memory, one record per slot
   logic [REC_W-1:0] mem [ENTRIES];

   kind_type           kind_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [FAM_W-1:0]   fam_ff;
   logic [VAL_W-1:0]   vhi_ff, vlo_ff;
   logic [TIME_W-1:0]  now_ff, exp_new_ff;
   logic [TTL_W-1:0]   ttl_ff;
   logic [CT_W-1:0]    count_ff, count_in;
   logic [CT_W-1:0]    scan_ff, scan_in;    // address being issued
   logic [CT_W-1:0]    rd_idx_ff;           // address of data in rd_ff
   logic               rd_vld_ff;
   rec_type            rd_ff;
   logic [CT_W-1:0]    kept_ff, kept_in;
   logic [PURGE_W-1:0] purged_ff, purged_in;
   logic [IDX_W-1:0]   match_idx_ff, victim_ff;
   logic [TIME_W-1:0]  victim_exp_ff;
   logic [CNT_W-1:0]   hit_ff, miss_ff;
   logic [CNT_W-1:0]   hit_in, miss_in;
   logic               div_done;
   logic [PCT_W-1:0]   div_pct;
   logic               rd_match, rd_live;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   rec_type            wr_data;

   assign rd_match = rd_vld_ff && rd_ff.key == key_ff && rd_ff.fam == fam_ff;
   assign rd_live  = now_ff < rd_ff.exp;

   // request capture and expiry computation (ttl*1000, registered from the captured fields)
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= kind_type'(req_kind);
         key_ff <= req_host_key;
         fam_ff <= req_family;
         vhi_ff <= req_addr_high;
         vlo_ff <= req_addr_low;
         ttl_ff <= req_ttl_seconds;
         now_ff <= req_now_ms;
      end
      exp_new_ff <= now_ff + TIME_W'(ttl_ff) * TIME_W'(MS_PER_S);
   end

   // scan index: issues the address in the cycle before the compare
   always_comb begin
      scan_in = scan_ff;
      kept_in = kept_ff;
      purged_in = purged_ff;
      count_in = count_ff;
      if (cmd.scan_start) begin
         scan_in = '0;
         kept_in = '0;
         purged_in = '0;
      end else if (cmd.scan_step) begin
         if (scan_ff < count_ff) scan_in = scan_ff + 1'b1;
         if (rd_vld_ff && kind_ff == KIND_PURGE) begin
            if (rd_live) kept_in = kept_ff + 1'b1;
            else purged_in = purged_ff + 1'b1;
         end
      end
      if (cmd.do_evict) count_in = count_ff - 1'b1;
      if (cmd.do_append) count_in = count_in + 1'b1;
      if (cmd.purge_fin) count_in = kept_ff;
   end

   // read only inside the table; rd_ff keeps the last entry read
   assign rd_en = cmd.scan_step && scan_ff < count_ff;
   assign rd_addr = scan_ff[IDX_W-1:0];

   // write port: update, eviction move, append or purge compaction
   always_comb begin
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = rd_ff;
      if (cmd.do_update) begin
         wr_en = 1'b1;
         wr_addr = match_idx_ff;
         wr_data = '{key: key_ff, fam: fam_ff, vhi: vhi_ff, vlo: vlo_ff, exp: exp_new_ff};
      end else if (cmd.do_evict) begin
         wr_en = 1'b1;
         wr_addr = victim_ff;
      end else if (cmd.do_append) begin
         wr_en = 1'b1;
         wr_addr = count_in[IDX_W-1:0] - 1'b1;
         wr_data = '{key: key_ff, fam: fam_ff, vhi: vhi_ff, vlo: vlo_ff, exp: exp_new_ff};
      end else if (cmd.scan_step && rd_vld_ff && kind_ff == KIND_PURGE && rd_live) begin
         wr_en = kept_ff != rd_idx_ff;
         wr_addr = kept_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= rec_type'(mem[rd_addr]);
   end

   // scan bookkeeping, first match and soonest-expiring victim
   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      kept_ff <= kept_in;
      purged_ff <= purged_in;
      if (rd_en) rd_idx_ff <= scan_ff;
      if (reset) begin
         count_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_vld_ff <= rd_en;
      end
      if (rd_match) match_idx_ff <= rd_idx_ff[IDX_W-1:0];
      if (cmd.scan_step && rd_vld_ff) begin
         if (rd_idx_ff == '0 || rd_ff.exp < victim_exp_ff) begin
            victim_ff <= rd_idx_ff[IDX_W-1:0];
            victim_exp_ff <= rd_ff.exp;
         end
      end
   end

   // hit and miss counters; the divider sees this transaction's update
   assign hit_in = cmd.hit ? hit_ff + 1'b1 : hit_ff;
   assign miss_in = cmd.miss ? miss_ff + 1'b1 : miss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= '0;
         miss_ff <= '0;
      end else begin
         hit_ff <= hit_in;
         miss_ff <= miss_in;
      end
   end

   ttlkc_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .hits   (hit_in),
      .misses (miss_in),
      .done   (div_done),
      .pct    (div_pct)
   );

   // result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status <= cmd.miss;
         rsp_found_addr_high <= cmd.hit ? rd_ff.vhi : '0;
         rsp_found_addr_low <= cmd.hit ? rd_ff.vlo : '0;
         rsp_purged_count <= kind_ff == KIND_PURGE ? purged_ff : '0;
      end
      if (div_done) rsp_hit_percent <= div_pct;
   end

   assign sts = '{kind: kind_ff,
                  scan_done: !rd_vld_ff && scan_ff >= count_ff && !cmd.scan_start,
                  match: rd_match,
                  live: rd_live,
                  full: count_ff >= CT_W'(ENTRIES),
                  div_done: div_done};
endmodule
`default_nettype wire

// File: rtl/core/ttlkc_ctrl.sv
// Controller: sequences scan, write-back, counter update, divide and response handshake.
`default_nettype none
module ttlkc_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire ttlkc_pkg::sts_type sts,
   output ttlkc_pkg::cmd_type      cmd
);
   import ttlkc_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_PREP  = 8'b0000_0010,
      ST_SCAN  = 8'b0000_0100,
      ST_VSCAN = 8'b0000_1000,
      ST_WRITE = 8'b0001_0000,
      ST_APPND = 8'b0010_0000,
      ST_DIV   = 8'b0100_0000,
      ST_RESP  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      found_ff, found_in;

   always_comb begin
      state_in = state_ff;
      found_in = found_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.scan_start = 1'b1;
            found_in = 1'b0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // stop at the first match for insert, lookup and query; the matched entry stays read
            if (sts.match && !found_ff && sts.kind != KIND_PURGE) begin
               found_in = 1'b1;
               state_in = ST_WRITE;
            end else if (sts.scan_done) begin
               state_in = ST_WRITE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_VSCAN: begin
            if (sts.scan_done) begin
               cmd.do_evict = 1'b1;
               state_in = ST_APPND;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_WRITE: begin
            unique case (sts.kind)
               KIND_INSERT: begin
                  if (found_ff) begin
                     cmd.do_update = 1'b1;
                     state_in = ST_DIV;
                  end else if (sts.full) begin
                     cmd.scan_start = 1'b1;
                     state_in = ST_VSCAN;
                  end else begin
                     state_in = ST_APPND;
                  end
               end
               KIND_LOOKUP: begin
                  cmd.hit = found_ff && sts.live;
                  cmd.miss = !(found_ff && sts.live);
                  cmd.rsp_load = 1'b1;
                  cmd.div_start = 1'b1;
                  state_in = ST_DIV;
               end
               KIND_PURGE: begin
                  cmd.purge_fin = 1'b1;
                  state_in = ST_DIV;
               end
               default: state_in = ST_DIV;
            endcase
            if (sts.kind != KIND_LOOKUP && !(sts.kind == KIND_INSERT && !found_ff)) begin
               cmd.rsp_load = 1'b1;
               cmd.div_start = 1'b1;
            end
         end
         ST_APPND: begin
            cmd.do_append = 1'b1;
            cmd.rsp_load = 1'b1;
            cmd.div_start = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = state_ff == ST_RESP;

   // checks on the sequencer
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_excl: assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("accept while result pending");
   a_hitmiss: assert property (@(posedge clock) disable iff (reset) !(cmd.hit && cmd.miss))
      else $error("hit and miss together");
   a_resp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped");
endmodule
`default_nettype wire

// File: rtl/core/ttl_keyed_cache_table_top.sv
// Top level of the expiring-entry cache table.
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_ready | kind, host_key, family, addr, ttl, now
//  rsp     | out       | rsp_valid/rsp_ready | status, found_addr, purged_count, hit_percent
// One transaction at a time. The scan reads one memory entry per cycle, and a match stops
// it early for insert, lookup and query; an insert that misses then appends, and an insert
// into a full table first rescans for the victim. The hit_percent result comes from a
// 39-step restoring divide.
// Synchronous reset clears count and counters; entry storage is not cleared.
// A stalled result holds the block; no new request is taken until it is accepted.
`default_nettype none
module ttl_keyed_cache_table_top #(
   parameter int ENTRIES = ttlkc_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [1:0]                   req_kind,
   input  wire logic [ttlkc_pkg::KEY_W-1:0]  req_host_key,
   input  wire logic [ttlkc_pkg::FAM_W-1:0]  req_family,
   input  wire logic [ttlkc_pkg::VAL_W-1:0]  req_addr_high,
   input  wire logic [ttlkc_pkg::VAL_W-1:0]  req_addr_low,
   input  wire logic [ttlkc_pkg::TTL_W-1:0]  req_ttl_seconds,
   input  wire logic [ttlkc_pkg::TIME_W-1:0] req_now_ms,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_status,
   output logic [ttlkc_pkg::VAL_W-1:0]       rsp_found_addr_high,
   output logic [ttlkc_pkg::VAL_W-1:0]       rsp_found_addr_low,
   output logic [ttlkc_pkg::PURGE_W-1:0]     rsp_purged_count,
   output logic [ttlkc_pkg::PCT_W-1:0]       rsp_hit_percent
);
   import ttlkc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ttlkc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ttlkc_datapath #(.ENTRIES(ENTRIES)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_kind            (req_kind),
      .req_host_key        (req_host_key),
      .req_family          (req_family),
      .req_addr_high       (req_addr_high),
      .req_addr_low        (req_addr_low),
      .req_ttl_seconds     (req_ttl_seconds),
      .req_now_ms          (req_now_ms),
      .rsp_status          (rsp_status),
      .rsp_found_addr_high (rsp_found_addr_high),
      .rsp_found_addr_low  (rsp_found_addr_low),
      .rsp_purged_count    (rsp_purged_count),
      .rsp_hit_percent     (rsp_hit_percent)
   );
endmodule
`default_nettype wire
